>>> design/sbl_pkg.sv
`default_nettype none

package sbl_pkg;

  localparam int LEN_BITS   = 16;
  localparam int START_BITS = 16;
  localparam int OUT_VALUE_BITS = 32;
  localparam int KW_COUNT   = 5;

  localparam int FIFO_DEPTH = 4;
  localparam int PTR_BITS   = $clog2(FIFO_DEPTH);
  localparam int CNT_BITS   = PTR_BITS + 1;

  localparam logic [3:0] TOK_UNKNOWN  = 4'd0;
  localparam logic [3:0] TOK_ID       = 4'd1;
  localparam logic [3:0] TOK_INT      = 4'd2;
  localparam logic [3:0] TOK_KW_FIRST = 4'd3;
  localparam logic [3:0] TOK_COLON    = 4'd8;
  localparam logic [3:0] TOK_DCOLON   = 4'd9;
  localparam logic [3:0] TOK_LCURLY   = 4'd10;
  localparam logic [3:0] TOK_RCURLY   = 4'd11;
  localparam logic [3:0] TOK_LPAREN   = 4'd12;
  localparam logic [3:0] TOK_RPAREN   = 4'd13;
  localparam logic [3:0] TOK_SEMI     = 4'd14;

  localparam logic [7:0] CH_NUL    = 8'h00;
  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_NL     = 8'h0A;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_COLON  = 8'h3A;
  localparam logic [7:0] CH_SEMI   = 8'h3B;
  localparam logic [7:0] CH_LPAREN = 8'h28;
  localparam logic [7:0] CH_RPAREN = 8'h29;
  localparam logic [7:0] CH_LCURLY = 8'h7B;
  localparam logic [7:0] CH_RCURLY = 8'h7D;

  localparam logic [7:0] KW_TEXT [KW_COUNT][8] = '{
    '{"n", "e", "w", 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
    '{"f", "u", "n", 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
    '{"m", "o", "d", "u", "l", "e", 8'h00, 8'h00},
    '{"r", "e", "t", "u", "r", "n", 8'h00, 8'h00},
    '{"I", "n", "t", 8'h00, 8'h00, 8'h00, 8'h00, 8'h00}
  };

  localparam logic [LEN_BITS-1:0] KW_LEN [KW_COUNT] = '{
    16'd3, 16'd3, 16'd6, 16'd6, 16'd3
  };

  typedef struct packed {
    logic [7:0] char_byte;
    logic       end_of_code;
  } byte_t;

  typedef struct packed {
    logic [3:0]                token_type;
    logic [START_BITS-1:0]     token_start;
    logic [LEN_BITS-1:0]       token_length;
    logic [OUT_VALUE_BITS-1:0] number_value;
    logic                      last_of_run;
  } token_t;

  typedef struct packed {
    logic [1:0] count;
    token_t     first;
    token_t     second;
  } push_t;

  function automatic logic is_letter(input logic [7:0] c);
    return (c >= "A" && c <= "Z") || (c >= "a" && c <= "z");
  endfunction

  function automatic logic is_digit(input logic [7:0] c);
    return c >= "0" && c <= "9";
  endfunction

  function automatic logic [3:0] single_type(input logic [7:0] c);
    logic [3:0] t;
    case (c)
      CH_LCURLY: t = TOK_LCURLY;
      CH_RCURLY: t = TOK_RCURLY;
      CH_LPAREN: t = TOK_LPAREN;
      CH_RPAREN: t = TOK_RPAREN;
      CH_SEMI:   t = TOK_SEMI;
      default:   t = TOK_UNKNOWN;
    endcase
    return t;
  endfunction

endpackage

`default_nettype wire

>>> design/source_byte_lexer_core.sv
// Bytes pass the input register; their tokens are written to the queue that drives token_word.
// Throughput: one byte per cycle while the queue has room and no byte gives two tokens;
//   a byte that gives two tokens pushes both at once into the 4-entry queue behind token_word.
// A byte held in the input register is lexed and released only when the queue has room for two tokens.
// Reset: synchronous rst empties the input register and the queue, sets the lexer idle,
//   the byte position to zero and the keyword match flags to all ones.
`default_nettype none

module source_byte_lexer_core #(
  parameter int POSITION_BITS = 16,
  parameter int VALUE_BITS    = 32
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            byte_valid,
  output logic            byte_stall,
  input  sbl_pkg::byte_t  byte_word,
  output logic            token_valid,
  input  logic            token_stall,
  output sbl_pkg::token_t token_word
);
  import sbl_pkg::*;

  byte_t in_q;
  logic  in_q_valid;
  logic  room;
  logic  advance;
  push_t push;

  assign advance    = in_q_valid & room;
  assign byte_stall = in_q_valid & ~room;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_q_valid <= 1'b0;
    end else if (!byte_stall) begin
      in_q_valid <= byte_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (byte_valid && !byte_stall) begin
      in_q <= byte_word;
    end
  end

  sbl_lexer #(
    .POSITION_BITS(POSITION_BITS),
    .VALUE_BITS   (VALUE_BITS)
  ) u_lexer (
    .clk    (clk),
    .rst    (rst),
    .advance(advance),
    .item   (in_q),
    .push   (push)
  );

  sbl_token_fifo u_fifo (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .room     (room),
    .out_valid(token_valid),
    .out_stall(token_stall),
    .out_word (token_word)
  );

  a_rise_after_push: assert property (@(posedge clk) disable iff (rst)
    $rose(token_valid) |-> $past(push.count != 2'd0))
    else $error("token_valid rose without a push");

  a_pair_last_flag: assert property (@(posedge clk) disable iff (rst)
    push.count == 2'd2 |-> (!push.first.last_of_run && push.second.last_of_run))
    else $error("last_of_run misplaced on a token pair");

  a_push_needs_advance: assert property (@(posedge clk) disable iff (rst)
    push.count != 2'd0 |-> (in_q_valid && room))
    else $error("token pushed without room");

  a_full_means_valid: assert property (@(posedge clk) disable iff (rst)
    !room |-> token_valid)
    else $error("queue reports no room while empty");

endmodule

`default_nettype wire

>>> design/sbl_token_fifo.sv
`default_nettype none

module sbl_token_fifo (
  input  logic           clk,
  input  logic           rst,
  input  sbl_pkg::push_t push,
  output logic           room,
  output logic           out_valid,
  input  logic           out_stall,
  output sbl_pkg::token_t out_word
);
  import sbl_pkg::*;

  token_t              entry [FIFO_DEPTH];
  logic [PTR_BITS-1:0] wr_ptr;
  logic [PTR_BITS-1:0] wr_ptr_plus;
  logic [PTR_BITS-1:0] rd_ptr;
  logic [CNT_BITS-1:0] count;
  logic                pop;

  assign out_valid   = (count != '0);
  assign out_word    = entry[rd_ptr];
  assign room        = (count <= CNT_BITS'(FIFO_DEPTH - 2));
  assign pop         = out_valid & ~out_stall;
  assign wr_ptr_plus = wr_ptr + 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      wr_ptr <= wr_ptr + PTR_BITS'(push.count);
      rd_ptr <= rd_ptr + PTR_BITS'(pop);
      count  <= count + CNT_BITS'(push.count) - CNT_BITS'(pop);
    end
  end

  always_ff @(posedge clk) begin
    if (push.count != 2'd0) begin
      entry[wr_ptr] <= push.first;
    end
    if (push.count == 2'd2) begin
      entry[wr_ptr_plus] <= push.second;
    end
  end

endmodule

`default_nettype wire

>>> design/sbl_lexer.sv
`default_nettype none

module sbl_lexer #(
  parameter int POSITION_BITS = 16,
  parameter int VALUE_BITS    = 32
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           advance,
  input  sbl_pkg::byte_t item,
  output sbl_pkg::push_t push
);
  import sbl_pkg::*;

  typedef enum logic [3:0] {
    MODE_IDLE  = 4'b0001,
    MODE_ID    = 4'b0010,
    MODE_NUM   = 4'b0100,
    MODE_COLON = 4'b1000
  } mode_t;

  mode_t                    mode, mode_next;
  logic [POSITION_BITS-1:0] position, position_next;
  logic [POSITION_BITS-1:0] run_start, run_start_next;
  logic [LEN_BITS-1:0]      run_length, run_length_next;
  logic [KW_COUNT-1:0]      keyword_match, keyword_match_next;
  logic [VALUE_BITS-1:0]    number_accum, number_accum_next;
  logic                     stopped, stopped_next;

  token_t     tok [2];
  logic [1:0] n;
  logic       used;
  logic       letter;
  logic       digit;
  logic [7:0] c;

  function automatic logic [KW_COUNT-1:0] kw_step(input logic [KW_COUNT-1:0] km,
                                                  input logic [LEN_BITS-1:0] len,
                                                  input logic [7:0]          ch);
    logic [KW_COUNT-1:0] r;
    r = km;
    for (int k = 0; k < KW_COUNT; k++) begin
      if (len >= KW_LEN[k] || KW_TEXT[k][len[2:0]] != ch) begin
        r[k] = 1'b0;
      end
    end
    return r;
  endfunction

  function automatic logic [VALUE_BITS-1:0] num_step(input logic [VALUE_BITS-1:0] acc,
                                                     input logic [7:0]            ch);
    logic [VALUE_BITS+3:0] wide;
    wide = {1'b0, acc, 3'b000} + {3'b000, acc, 1'b0} + (VALUE_BITS + 4)'(ch[3:0]);
    if (wide[VALUE_BITS+3:VALUE_BITS] != 4'd0) begin
      return '1;
    end
    return wide[VALUE_BITS-1:0];
  endfunction

  function automatic logic [LEN_BITS-1:0] len_inc(input logic [LEN_BITS-1:0] len);
    return (len == '1) ? len : len + 1'b1;
  endfunction

  function automatic token_t flush_tok(input mode_t                    m,
                                       input logic [POSITION_BITS-1:0] st,
                                       input logic [LEN_BITS-1:0]      ln,
                                       input logic [KW_COUNT-1:0]      km,
                                       input logic [VALUE_BITS-1:0]    ac);
    token_t t;
    t = '0;
    t.token_start  = START_BITS'(st);
    t.token_length = ln;
    if (m == MODE_ID) begin
      t.token_type = TOK_ID;
      for (int k = KW_COUNT - 1; k >= 0; k--) begin
        if (km[k] && ln == KW_LEN[k]) begin
          t.token_type = TOK_KW_FIRST + 4'(k);
        end
      end
    end else if (m == MODE_NUM) begin
      t.token_type   = TOK_INT;
      t.number_value = OUT_VALUE_BITS'(ac);
    end else begin
      t.token_type   = TOK_COLON;
      t.token_length = LEN_BITS'(1);
    end
    return t;
  endfunction

  always_comb begin
    mode_next          = mode;
    position_next      = position;
    run_start_next     = run_start;
    run_length_next    = run_length;
    keyword_match_next = keyword_match;
    number_accum_next  = number_accum;
    stopped_next       = stopped;
    tok[0]             = '0;
    tok[1]             = '0;
    n                  = 2'd0;
    used               = 1'b0;
    c                  = item.char_byte;
    letter             = is_letter(c);
    digit              = is_digit(c);

    if (c == CH_NUL) begin
      if (!stopped && mode != MODE_IDLE) begin
        tok[0] = flush_tok(mode, run_start, run_length, keyword_match, number_accum);
        n      = 2'd1;
      end
      mode_next          = MODE_IDLE;
      position_next      = '0;
      run_start_next     = '0;
      run_length_next    = '0;
      keyword_match_next = '1;
      number_accum_next  = '0;
      stopped_next       = 1'b0;
    end else if (!stopped) begin
      unique case (mode)
        MODE_ID: begin
          if (letter || digit) begin
            keyword_match_next = kw_step(keyword_match, run_length, c);
            run_length_next    = len_inc(run_length);
            used               = 1'b1;
          end else begin
            tok[0]    = flush_tok(mode, run_start, run_length, keyword_match, number_accum);
            n         = 2'd1;
            mode_next = MODE_IDLE;
          end
        end
        MODE_NUM: begin
          if (digit) begin
            number_accum_next = num_step(number_accum, c);
            run_length_next   = len_inc(run_length);
            used              = 1'b1;
          end else begin
            tok[0]    = flush_tok(mode, run_start, run_length, keyword_match, number_accum);
            n         = 2'd1;
            mode_next = MODE_IDLE;
          end
        end
        MODE_COLON: begin
          if (c == CH_COLON) begin
            tok[0].token_type   = TOK_DCOLON;
            tok[0].token_start  = START_BITS'(run_start);
            tok[0].token_length = LEN_BITS'(2);
            used                = 1'b1;
          end else begin
            tok[0] = flush_tok(mode, run_start, run_length, keyword_match, number_accum);
          end
          n         = 2'd1;
          mode_next = MODE_IDLE;
        end
        MODE_IDLE: begin
        end
        default: begin
        end
      endcase

      if (!used && !(c == CH_SPACE || c == CH_TAB || c == CH_NL)) begin
        if (letter || digit || c == CH_COLON) begin
          run_start_next     = position;
          run_length_next    = LEN_BITS'(1);
          keyword_match_next = '1;
          number_accum_next  = '0;
          if (letter) begin
            mode_next          = MODE_ID;
            keyword_match_next = kw_step('1, '0, c);
          end else if (digit) begin
            mode_next         = MODE_NUM;
            number_accum_next = num_step('0, c);
          end else begin
            mode_next = MODE_COLON;
          end
        end else begin
          tok[n[0]].token_type   = single_type(c);
          tok[n[0]].token_start  = START_BITS'(position);
          tok[n[0]].token_length = LEN_BITS'(1);
          n = n + 2'd1;
        end
      end

      position_next = position + 1'b1;

      if (item.end_of_code) begin
        if (mode_next != MODE_IDLE) begin
          tok[n[0]] = flush_tok(mode_next, run_start_next, run_length_next,
                                keyword_match_next, number_accum_next);
          n = n + 2'd1;
        end
        mode_next    = MODE_IDLE;
        stopped_next = 1'b1;
      end
    end

    if (n == 2'd2) begin
      tok[1].last_of_run = 1'b1;
    end else if (n == 2'd1) begin
      tok[0].last_of_run = 1'b1;
    end
  end

  assign push.count  = advance ? n : 2'd0;
  assign push.first  = tok[0];
  assign push.second = tok[1];

  always_ff @(posedge clk) begin
    if (rst) begin
      mode          <= MODE_IDLE;
      position      <= '0;
      run_start     <= '0;
      run_length    <= '0;
      keyword_match <= '1;
      number_accum  <= '0;
      stopped       <= 1'b0;
    end else if (advance) begin
      mode          <= mode_next;
      position      <= position_next;
      run_start     <= run_start_next;
      run_length    <= run_length_next;
      keyword_match <= keyword_match_next;
      number_accum  <= number_accum_next;
      stopped       <= stopped_next;
    end
  end

endmodule

`default_nettype wire

>>> verif/lexer_token_check.sv
`default_nettype none

module lexer_token_check (
  input  logic            clk,
  input  logic            rst,
  input  logic            byte_valid,
  input  logic            byte_stall,
  input  sbl_pkg::byte_t  byte_word,
  input  logic            token_valid,
  input  logic            token_stall,
  input  sbl_pkg::token_t token_word,
  output int              fail_count,
  output int              pending
);
  timeunit 1ns;
  timeprecision 1ps;

  import sbl_pkg::*;

  typedef enum logic [1:0] {SCAN_IDLE, SCAN_WORD, SCAN_NUMBER, SCAN_COLON} scan_mode_t;

  scan_mode_t  mode;
  logic [15:0] position;
  logic [15:0] run_start;
  logic [15:0] run_len;
  logic [4:0]  kw_live;
  logic [31:0] accum;
  logic        halted;
  token_t      expected_tokens [$];

  function automatic string kw_spelling(input int k);
    case (k)
      0: return "new";
      1: return "fun";
      2: return "module";
      3: return "return";
      default: return "Int";
    endcase
  endfunction

  function automatic logic letter_byte(input logic [7:0] c);
    return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
  endfunction

  function automatic logic digit_byte(input logic [7:0] c);
    return c >= "0" && c <= "9";
  endfunction

  function automatic logic [3:0] punct_token(input logic [7:0] c);
    case (c)
      CH_LCURLY: return TOK_LCURLY;
      CH_RCURLY: return TOK_RCURLY;
      CH_LPAREN: return TOK_LPAREN;
      CH_RPAREN: return TOK_RPAREN;
      CH_SEMI:   return TOK_SEMI;
      default:   return TOK_UNKNOWN;
    endcase
  endfunction

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("[%0t] lexer token mismatch: %s got 0x%0h, want 0x%0h", $realtime, what, got,
             want);
    fail_count++;
  endtask

  task automatic clear_scan();
    mode      = SCAN_IDLE;
    position  = '0;
    run_start = '0;
    run_len   = '0;
    kw_live   = 5'h1F;
    accum     = '0;
    halted    = 1'b0;
  endtask

  task automatic queue_token(input logic [3:0] kind, input logic [15:0] start,
                             input logic [15:0] len, input logic [31:0] value);
    token_t t;
    t.token_type   = kind;
    t.token_start  = start;
    t.token_length = len;
    t.number_value = value;
    t.last_of_run  = 1'b0;
    expected_tokens.push_back(t);
  endtask

  task automatic grow_word(input logic [7:0] c);
    string s;
    for (int k = 0; k < 5; k++) begin
      s = kw_spelling(k);
      if (run_len >= s.len() || s[run_len] != c) kw_live[k] = 1'b0;
    end
    if (run_len != 16'hFFFF) run_len++;
  endtask

  task automatic grow_number(input logic [7:0] c);
    logic [63:0] wide;
    wide = 64'(accum) * 64'd10 + 64'(c - 8'h30);
    if (wide > 64'hFFFF_FFFF) accum = '1;
    else accum = wide[31:0];
    if (run_len != 16'hFFFF) run_len++;
  endtask

  task automatic close_run();
    logic [3:0] kind;
    string      s;
    case (mode)
      SCAN_WORD: begin
        kind = TOK_ID;
        for (int k = 4; k >= 0; k--) begin
          s = kw_spelling(k);
          if (kw_live[k] && run_len == s.len()) kind = TOK_KW_FIRST + 4'(k);
        end
        queue_token(kind, run_start, run_len, '0);
      end
      SCAN_NUMBER: queue_token(TOK_INT, run_start, run_len, accum);
      SCAN_COLON:  queue_token(TOK_COLON, run_start, 16'd1, '0);
      default: ;
    endcase
    mode = SCAN_IDLE;
  endtask

  task automatic lex_byte(input byte_t w);
    logic [7:0] c;
    logic       consumed;
    int         base;
    token_t     t;
    c        = w.char_byte;
    consumed = 1'b0;
    base     = expected_tokens.size();
    if (c == CH_NUL) begin
      if (!halted) close_run();
      clear_scan();
    end else if (!halted) begin
      case (mode)
        SCAN_WORD: begin
          if (letter_byte(c) || digit_byte(c)) begin
            grow_word(c);
            consumed = 1'b1;
          end else close_run();
        end
        SCAN_NUMBER: begin
          if (digit_byte(c)) begin
            grow_number(c);
            consumed = 1'b1;
          end else close_run();
        end
        SCAN_COLON: begin
          if (c == CH_COLON) begin
            queue_token(TOK_DCOLON, run_start, 16'd2, '0);
            mode     = SCAN_IDLE;
            consumed = 1'b1;
          end else close_run();
        end
        default: ;
      endcase
      if (!consumed && c != CH_SPACE && c != CH_TAB && c != CH_NL) begin
        if (letter_byte(c) || digit_byte(c) || c == CH_COLON) begin
          run_start = position;
          run_len   = '0;
          kw_live   = 5'h1F;
          accum     = '0;
          if (letter_byte(c)) begin
            mode = SCAN_WORD;
            grow_word(c);
          end else if (digit_byte(c)) begin
            mode = SCAN_NUMBER;
            grow_number(c);
          end else begin
            mode    = SCAN_COLON;
            run_len = 16'd1;
          end
        end else begin
          queue_token(punct_token(c), position, 16'd1, '0);
        end
      end
      position = position + 16'd1;
      if (w.end_of_code) begin
        close_run();
        halted = 1'b1;
      end
    end
    if (expected_tokens.size() > base) begin
      t = expected_tokens.pop_back();
      t.last_of_run = 1'b1;
      expected_tokens.push_back(t);
    end
  endtask

  task automatic check_token(input token_t got);
    token_t want;
    if (expected_tokens.size() == 0) begin
      report_mismatch("token with nothing expected, type", 32'(got.token_type), '0);
    end else begin
      want = expected_tokens.pop_front();
      if (got.token_type !== want.token_type)
        report_mismatch("token_type", 32'(got.token_type), 32'(want.token_type));
      if (got.token_start !== want.token_start)
        report_mismatch("token_start", 32'(got.token_start), 32'(want.token_start));
      if (got.token_length !== want.token_length)
        report_mismatch("token_length", 32'(got.token_length), 32'(want.token_length));
      if (got.number_value !== want.number_value)
        report_mismatch("number_value", got.number_value, want.number_value);
      if (got.last_of_run !== want.last_of_run)
        report_mismatch("last_of_run", 32'(got.last_of_run), 32'(want.last_of_run));
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      clear_scan();
      expected_tokens.delete();
      fail_count = 0;
    end else begin
      if (token_valid && !token_stall) check_token(token_word);
      if (byte_valid && !byte_stall) lex_byte(byte_word);
    end
    pending = expected_tokens.size();
  end

endmodule

`default_nettype wire

>>> verif/tb_top.sv
`default_nettype none

module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import sbl_pkg::*;

  logic   clk         = 1'b0;
  logic   rst         = 1'b1;
  logic   byte_valid  = 1'b0;
  logic   byte_stall;
  byte_t  byte_word   = '0;
  logic   token_valid;
  logic   token_stall = 1'b0;
  token_t token_word;
  int     fail_count;
  int     pending;

  int bytes_sent  = 0;
  int burst_left  = 0;
  int next_pause  = 300;
  bit code_closed = 1'b0;

  int         stall_left  = 0;
  logic [1:0] stall_style = '0;
  int         cyc         = 0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  source_byte_lexer_core uut (
    .clk         (clk),
    .rst         (rst),
    .byte_valid  (byte_valid),
    .byte_stall  (byte_stall),
    .byte_word   (byte_word),
    .token_valid (token_valid),
    .token_stall (token_stall),
    .token_word  (token_word)
  );

  lexer_token_check token_check (
    .clk         (clk),
    .rst         (rst),
    .byte_valid  (byte_valid),
    .byte_stall  (byte_stall),
    .byte_word   (byte_word),
    .token_valid (token_valid),
    .token_stall (token_stall),
    .token_word  (token_word),
    .fail_count  (fail_count),
    .pending     (pending)
  );

  always @(posedge clk) begin
    cyc++;
    if (stall_left == 0) begin
      stall_style = 2'($urandom_range(0, 3));
      stall_left  = $urandom_range(20, 120);
    end else stall_left--;
    case (stall_style)
      2'd0: token_stall <= 1'b0;
      2'd1: token_stall <= ($urandom_range(0, 9) < 3);
      2'd2: token_stall <= ($urandom_range(0, 9) < 7);
      default: token_stall <= cyc[2];
    endcase
  end

  function automatic string keyword_spelling(input int k);
    case (k)
      0: return "new";
      1: return "fun";
      2: return "module";
      3: return "return";
      default: return "Int";
    endcase
  endfunction

  function automatic logic rand_eoc();
    return $urandom_range(0, 49) == 0;
  endfunction

  function automatic logic [7:0] any_letter();
    if ($urandom_range(0, 1)) return 8'($urandom_range(8'h41, 8'h5A));
    return 8'($urandom_range(8'h61, 8'h7A));
  endfunction

  function automatic logic [7:0] any_alnum();
    if ($urandom_range(0, 3) == 0) return 8'($urandom_range(8'h30, 8'h39));
    return any_letter();
  endfunction

  task automatic send_byte(input logic [7:0] c, input logic eoc);
    byte_word  <= '{char_byte: c, end_of_code: eoc};
    byte_valid <= 1'b1;
    do @(posedge clk); while (byte_stall);
    if (c == CH_NUL) code_closed = 1'b0;
    else if (eoc) code_closed = 1'b1;
    bytes_sent++;
    if (burst_left > 0) burst_left--;
    else begin
      byte_valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(30, 80)
                                               : $urandom_range(0, 8);
    end
  endtask

  task automatic send_text(input string s, input bit noisy);
    for (int i = 0; i < s.len(); i++) send_byte(s[i], noisy ? rand_eoc() : 1'b0);
  endtask

  task automatic send_blank();
    int n;
    n = $urandom_range(1, 3);
    repeat (n) begin
      case ($urandom_range(0, 2))
        0: send_byte(CH_SPACE, rand_eoc());
        1: send_byte(CH_TAB, rand_eoc());
        default: send_byte(CH_NL, rand_eoc());
      endcase
    end
  endtask

  task automatic send_keyword();
    string s;
    int    n;
    s = keyword_spelling($urandom_range(0, 4));
    n = s.len();
    case ($urandom_range(0, 3))
      2: n = n - 1;
      default: ;
    endcase
    for (int i = 0; i < n; i++) send_byte(s[i], rand_eoc());
    if ($urandom_range(0, 5) == 0) send_byte(any_alnum(), rand_eoc());
  endtask

  task automatic send_identifier();
    int n;
    n = $urandom_range(0, 7);
    send_byte(any_letter(), rand_eoc());
    repeat (n) send_byte(any_alnum(), rand_eoc());
  endtask

  task automatic send_number();
    int n;
    case ($urandom_range(0, 7))
      0: send_text("4294967295", 1'b1);
      1: send_text("4294967296", 1'b1);
      2: send_text("99999999999999", 1'b1);
      default: begin
        n = $urandom_range(1, 6);
        repeat (n) send_byte(8'($urandom_range(8'h30, 8'h39)), rand_eoc());
      end
    endcase
  endtask

  task automatic send_punct();
    case ($urandom_range(0, 6))
      0: send_byte(CH_COLON, rand_eoc());
      1: begin
        send_byte(CH_COLON, rand_eoc());
        send_byte(CH_COLON, rand_eoc());
      end
      2: send_byte(CH_LCURLY, rand_eoc());
      3: send_byte(CH_RCURLY, rand_eoc());
      4: send_byte(CH_LPAREN, rand_eoc());
      5: send_byte(CH_RPAREN, rand_eoc());
      default: send_byte(CH_SEMI, rand_eoc());
    endcase
  endtask

  task automatic drain_tokens();
    byte_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  initial begin
    int pick;
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    send_text("new fun(Int)::{}:;", 1'b0);
    send_byte(8'hFF, 1'b0);
    send_byte("a", 1'b0);
    send_byte("b", 1'b1);
    send_byte("x", 1'b0);
    send_byte(CH_NUL, 1'b0);
    send_byte("7", 1'b0);
    send_byte(CH_NUL, 1'b0);
    drain_tokens();

    while (bytes_sent < 840) begin
      if (bytes_sent >= next_pause) begin
        drain_tokens();
        next_pause += 300;
      end
      if (code_closed) begin
        repeat ($urandom_range(0, 3))
          send_byte(8'($urandom_range(1, 255)), 1'($urandom_range(0, 1)));
        send_byte(CH_NUL, 1'($urandom_range(0, 1)));
      end else begin
        pick = $urandom_range(0, 99);
        if (pick < 25) send_keyword();
        else if (pick < 45) send_identifier();
        else if (pick < 63) send_number();
        else if (pick < 78) send_punct();
        else if (pick < 88) send_blank();
        else if (pick < 96) send_byte(8'($urandom_range(1, 255)), rand_eoc());
        else if (pick < 98) send_byte(CH_NUL, 1'($urandom_range(0, 1)));
        else send_byte(any_alnum(), 1'b1);
        if (pick < 63 && $urandom_range(0, 9) < 6) send_blank();
      end
    end

    drain_tokens();
    repeat (20) @(posedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("[source_byte_lexer_core] OK");
    end else begin
      $display("[source_byte_lexer_core] ERROR");
    end
    $finish;
  end

  initial begin
    #4_000_000;
    $display("[source_byte_lexer_core] ERROR");
    $finish;
  end

endmodule

`default_nettype wire

>>> filelist.f
design/sbl_pkg.sv
design/sbl_token_fifo.sv
design/sbl_lexer.sv
design/source_byte_lexer_core.sv
verif/lexer_token_check.sv
verif/tb_top.sv
